// File: rtl/multi_vehicle_pi_drive_unit_macros.svh
// Assertion macros used by the checker file of the drive unit.
`ifndef MULTI_VEHICLE_PI_DRIVE_UNIT_MACROS_SVH
`define MULTI_VEHICLE_PI_DRIVE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the clock, off while reset is high.
`define MVPD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the clock, off while reset is high.
`define MVPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/mvpd_pkg.sv
// Types, constants and the microcode table of the multi-vehicle PI drive unit.
`default_nettype none

package mvpd_pkg;

   localparam int VEHICLES_DEF = 3;
   localparam int STEP_W       = 3;

   // Configuration register indexes.
   localparam logic [2:0] CSR_OWN_INDEX       = 3'd0;
   localparam logic [2:0] CSR_INTEGRAL_GAINS  = 3'd1;
   localparam logic [2:0] CSR_POSITION_GAINS  = 3'd2;
   localparam logic [2:0] CSR_VELOCITY_GAINS  = 3'd3;
   localparam logic [2:0] CSR_INTEGRAL_LIMITS = 3'd4;
   localparam logic [2:0] CSR_PERIOD_SCALE    = 3'd5;

   // Drive limits, plus and minus 1.0 in Q1.14.
   localparam logic signed [15:0] DRIVE_MAX = 16'sd16384;
   localparam logic signed [15:0] DRIVE_MIN = -16'sd16384;

   // Microprogram addresses.
   localparam logic [STEP_W-1:0] STEP_START   = 3'd0;
   localparam logic [STEP_W-1:0] STEP_INTEG   = 3'd1;
   localparam logic [STEP_W-1:0] STEP_MUL_INT = 3'd2;
   localparam logic [STEP_W-1:0] STEP_ADD_INT = 3'd3;
   localparam logic [STEP_W-1:0] STEP_ADD_POS = 3'd4;
   localparam logic [STEP_W-1:0] STEP_ADD_VEL = 3'd5;
   localparam logic [STEP_W-1:0] STEP_FINISH  = 3'd6;
   localparam logic [STEP_W-1:0] STEP_STOP    = 3'd7;

   typedef enum logic [2:0] {
      MUL_NONE   = 3'd0,
      MUL_PERIOD = 3'd1,
      MUL_INTG   = 3'd2,
      MUL_POSG   = 3'd3,
      MUL_VELG   = 3'd4
   } mul_op_type;

   typedef enum logic [2:0] {
      ACC_NONE  = 3'd0,
      ACC_INTEG = 3'd1,
      ACC_TINT  = 3'd2,
      ACC_TPOS  = 3'd3,
      ACC_TVEL  = 3'd4
   } acc_op_type;

   typedef enum logic [1:0] {
      JMP_NEVER      = 2'd0,
      JMP_STOPPED    = 2'd1,
      JMP_NO_VEHICLE = 2'd2
   } jmp_cond_type;

   typedef enum logic [1:0] {
      FIN_NONE = 2'd0,
      FIN_RUN  = 2'd1,
      FIN_STOP = 2'd2
   } fin_op_type;

   typedef struct packed {
      mul_op_type          mul_op;
      acc_op_type          acc_op;
      jmp_cond_type        jmp_cond;
      logic [STEP_W-1:0]   jmp_target;
      fin_op_type          fin_op;
   } ctrl_word_type;

   // A step whose jump is taken does none of its datapath work.
   function automatic ctrl_word_type ucode_rom(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw            = '0;
      cw.mul_op     = MUL_NONE;
      cw.acc_op     = ACC_NONE;
      cw.jmp_cond   = JMP_NEVER;
      cw.jmp_target = STEP_START;
      cw.fin_op     = FIN_NONE;
      case (step)
         STEP_START: begin
            cw.mul_op     = MUL_PERIOD;
            cw.jmp_cond   = JMP_STOPPED;
            cw.jmp_target = STEP_STOP;
         end
         STEP_INTEG: begin
            cw.acc_op     = ACC_INTEG;
            cw.jmp_cond   = JMP_NO_VEHICLE;
            cw.jmp_target = STEP_FINISH;
         end
         STEP_MUL_INT: begin
            cw.mul_op = MUL_INTG;
         end
         STEP_ADD_INT: begin
            cw.mul_op = MUL_POSG;
            cw.acc_op = ACC_TINT;
         end
         STEP_ADD_POS: begin
            cw.mul_op = MUL_VELG;
            cw.acc_op = ACC_TPOS;
         end
         STEP_ADD_VEL: begin
            cw.acc_op = ACC_TVEL;
         end
         STEP_FINISH: begin
            cw.fin_op = FIN_RUN;
         end
         STEP_STOP: begin
            cw.fin_op = FIN_STOP;
         end
         default: begin
            cw.fin_op = FIN_STOP;
         end
      endcase
      return cw;
   endfunction

   function automatic logic signed [15:0] gain_sel(input logic [47:0] packed_gains,
                                                   input logic [1:0]  idx);
      logic signed [15:0] g;
      case (idx)
         2'd0:    g = packed_gains[15:0];
         2'd1:    g = packed_gains[31:16];
         2'd2:    g = packed_gains[47:32];
         default: g = 16'sd0;
      endcase
      return g;
   endfunction

   function automatic logic [19:0] limit_sel(input logic [59:0] packed_limits,
                                             input logic [1:0]  idx);
      logic [19:0] l;
      case (idx)
         2'd0:    l = packed_limits[19:0];
         2'd1:    l = packed_limits[39:20];
         2'd2:    l = packed_limits[59:40];
         default: l = 20'd0;
      endcase
      return l;
   endfunction

endpackage

`default_nettype wire

// File: rtl/multi_vehicle_pi_drive_unit.sv
// Multi-vehicle PI drive unit: one vehicle beat in, a drive beat out per control period.
//
// Each request beat describes one vehicle; the beat flagged last_vehicle closes the
// control period and returns the clamped drive. A stopped beat returns drive 0 at once,
// clears the integrals and flags a recalibration on the first stop after running.
// The beat is run by a small microprogram over one shared 17x40 signed multiplier,
// used four times for a running beat of a known vehicle. A stopped beat jumps from the
// start step to the stop step and a beat with an unknown vehicle index from the integral
// step to the finish step. A new beat is taken only when the previous one is done; a
// result waits in the response register, and the block stalls on its final step only
// when a new result meets a response that has not yet been taken. The user must write
// configuration through the csr port while the block is idle; it is not enforced.
`default_nettype none

module multi_vehicle_pi_drive_unit #(
   parameter int VEHICLES = mvpd_pkg::VEHICLES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wen,
   input  logic [2:0]         csr_index,
   input  logic [59:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_running,
   input  logic signed [15:0] req_setpoint_position,
   input  logic signed [15:0] req_setpoint_velocity,
   input  logic signed [15:0] req_own_position,
   input  logic [1:0]         req_vehicle_index,
   input  logic signed [15:0] req_vehicle_position,
   input  logic signed [15:0] req_vehicle_velocity,
   input  logic               req_last_vehicle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_drive,
   output logic               rsp_recalibrate,
   output logic signed [16:0] rsp_position_offset
);

   localparam int IDX_W = (VEHICLES > 1) ? $clog2(VEHICLES) : 1;

   // Configuration registers.
   logic [1:0]  own_index_ff,       own_index_in;
   logic [47:0] integral_gains_ff,  integral_gains_in;
   logic [47:0] position_gains_ff,  position_gains_in;
   logic [47:0] velocity_gains_ff,  velocity_gains_in;
   logic [59:0] integral_limits_ff, integral_limits_in;
   logic [15:0] period_scale_ff,    period_scale_in;

   // Captured request beat.
   logic               running_ff, running_in;
   logic signed [15:0] sp_pos_ff,  sp_pos_in;
   logic signed [15:0] sp_vel_ff,  sp_vel_in;
   logic signed [15:0] own_pos_ff, own_pos_in;
   logic [1:0]         vi_ff,      vi_in;
   logic signed [15:0] veh_pos_ff, veh_pos_in;
   logic signed [15:0] veh_vel_ff, veh_vel_in;
   logic               last_ff,    last_in;

   // Sequencer.
   logic                        busy_ff, busy_in;
   logic [mvpd_pkg::STEP_W-1:0] step_ff, step_in;

   // Datapath and controller state.
   logic signed [56:0] prod_ff,  prod_in;
   logic signed [39:0] acc_ff,   acc_in;
   logic signed [39:0] integ_ff [VEHICLES];
   logic signed [39:0] integ_in [VEHICLES];
   logic signed [47:0] sum_ff,   sum_in;
   logic signed [15:0] stored_sp_ff, stored_sp_in;
   logic               was_running_ff, was_running_in;

   // Response register.
   logic               rsp_valid_ff,  rsp_valid_in;
   logic signed [15:0] rsp_drive_ff,  rsp_drive_in;
   logic               rsp_recal_ff,  rsp_recal_in;
   logic signed [16:0] rsp_offset_ff, rsp_offset_in;

   // Combinational signals.
   mvpd_pkg::ctrl_word_type cw;
   logic               accept;
   logic               vi_ok;
   logic               jump_take;
   logic               out_free;
   logic signed [16:0] integ_err;
   logic signed [16:0] pos_err;
   logic signed [16:0] vel_err;
   logic signed [15:0] gain_i;
   logic signed [15:0] gain_p;
   logic signed [15:0] gain_v;
   logic signed [16:0] mul_a;
   logic signed [39:0] mul_b;
   logic signed [56:0] mul_p;
   logic signed [39:0] integ_cur;
   logic signed [40:0] acc_sum;
   logic signed [40:0] lim_pos;
   logic signed [40:0] lim_neg;
   logic signed [40:0] acc_clamp;
   logic [48:0]        term;
   logic               term_cin;
   logic [48:0]        sum_wide;
   logic signed [47:0] sum_sat;
   logic signed [15:0] drive_clamp;
   logic signed [16:0] offset_diff;

   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign cw    = mvpd_pkg::ucode_rom(step_ff);
   assign vi_ok = ({1'b0, vi_ff} < 3'(VEHICLES));

   always_comb begin
      case (cw.jmp_cond)
         mvpd_pkg::JMP_NEVER:      jump_take = 1'b0;
         mvpd_pkg::JMP_STOPPED:    jump_take = !running_ff;
         mvpd_pkg::JMP_NO_VEHICLE: jump_take = !vi_ok;
         default:                  jump_take = 1'b0;
      endcase
   end

   // Error terms, all 17 bits wide.
   assign integ_err = {sp_pos_ff[15], sp_pos_ff} - {own_pos_ff[15], own_pos_ff};
   assign pos_err   = (vi_ff == own_index_ff) ? integ_err
                      : ({sp_pos_ff[15], sp_pos_ff} - {veh_pos_ff[15], veh_pos_ff});
   assign vel_err   = {sp_vel_ff[15], sp_vel_ff} - {veh_vel_ff[15], veh_vel_ff};

   assign gain_i = mvpd_pkg::gain_sel(integral_gains_ff, vi_ff);
   assign gain_p = mvpd_pkg::gain_sel(position_gains_ff, vi_ff);
   assign gain_v = mvpd_pkg::gain_sel(velocity_gains_ff, vi_ff);

   // Shared multiplier operand selection.
   always_comb begin
      case (cw.mul_op)
         mvpd_pkg::MUL_PERIOD: begin
            mul_a = {1'b0, period_scale_ff};
            mul_b = {{23{integ_err[16]}}, integ_err};
         end
         mvpd_pkg::MUL_INTG: begin
            mul_a = {gain_i[15], gain_i};
            mul_b = acc_ff;
         end
         mvpd_pkg::MUL_POSG: begin
            mul_a = {gain_p[15], gain_p};
            mul_b = {{23{pos_err[16]}}, pos_err};
         end
         mvpd_pkg::MUL_VELG: begin
            mul_a = {gain_v[15], gain_v};
            mul_b = {{23{vel_err[16]}}, vel_err};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Integral update with clamp to plus or minus the limit in Q.16.
   assign integ_cur = integ_ff[vi_ff[IDX_W-1:0]];
   assign acc_sum   = {integ_cur[39], integ_cur} + prod_ff[40:0];
   assign lim_pos   = {5'b0, mvpd_pkg::limit_sel(integral_limits_ff, vi_ff), 16'b0};
   assign lim_neg   = -lim_pos;

   always_comb begin
      if (acc_sum > lim_pos) begin
         acc_clamp = lim_pos;
      end else if (acc_sum < lim_neg) begin
         acc_clamp = lim_neg;
      end else begin
         acc_clamp = acc_sum;
      end
   end

   // Rounding half up after an arithmetic shift is the shifted value plus the
   // highest dropped bit, so it rides on the adder's carry-in.
   always_comb begin
      case (cw.acc_op)
         mvpd_pkg::ACC_TINT: begin
            term     = {{6{prod_ff[56]}}, prod_ff[56:14]};
            term_cin = prod_ff[13];
         end
         mvpd_pkg::ACC_TPOS: begin
            term     = {prod_ff[46:0], 2'b00};
            term_cin = 1'b0;
         end
         mvpd_pkg::ACC_TVEL: begin
            term     = prod_ff[54:6];
            term_cin = prod_ff[5];
         end
         default: begin
            term     = '0;
            term_cin = 1'b0;
         end
      endcase
   end

   assign sum_wide = {sum_ff[47], sum_ff} + term + {48'b0, term_cin};

   always_comb begin
      if (sum_wide[48] != sum_wide[47]) begin
         sum_sat = sum_wide[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
      end else begin
         sum_sat = sum_wide[47:0];
      end
   end

   always_comb begin
      if (sum_ff > 48'(mvpd_pkg::DRIVE_MAX)) begin
         drive_clamp = mvpd_pkg::DRIVE_MAX;
      end else if (sum_ff < 48'(mvpd_pkg::DRIVE_MIN)) begin
         drive_clamp = mvpd_pkg::DRIVE_MIN;
      end else begin
         drive_clamp = sum_ff[15:0];
      end
   end

   assign offset_diff = {own_pos_ff[15], own_pos_ff} - {stored_sp_ff[15], stored_sp_ff};

   // Next-state logic.
   always_comb begin
      own_index_in       = own_index_ff;
      integral_gains_in  = integral_gains_ff;
      position_gains_in  = position_gains_ff;
      velocity_gains_in  = velocity_gains_ff;
      integral_limits_in = integral_limits_ff;
      period_scale_in    = period_scale_ff;

      running_in = running_ff;
      sp_pos_in  = sp_pos_ff;
      sp_vel_in  = sp_vel_ff;
      own_pos_in = own_pos_ff;
      vi_in      = vi_ff;
      veh_pos_in = veh_pos_ff;
      veh_vel_in = veh_vel_ff;
      last_in    = last_ff;

      busy_in        = busy_ff;
      step_in        = step_ff;
      prod_in        = prod_ff;
      acc_in         = acc_ff;
      integ_in       = integ_ff;
      sum_in         = sum_ff;
      stored_sp_in   = stored_sp_ff;
      was_running_in = was_running_ff;

      rsp_valid_in  = rsp_valid_ff;
      rsp_drive_in  = rsp_drive_ff;
      rsp_recal_in  = rsp_recal_ff;
      rsp_offset_in = rsp_offset_ff;

      if (csr_wen) begin
         case (csr_index)
            mvpd_pkg::CSR_OWN_INDEX:       own_index_in       = csr_wdata[1:0];
            mvpd_pkg::CSR_INTEGRAL_GAINS:  integral_gains_in  = csr_wdata[47:0];
            mvpd_pkg::CSR_POSITION_GAINS:  position_gains_in  = csr_wdata[47:0];
            mvpd_pkg::CSR_VELOCITY_GAINS:  velocity_gains_in  = csr_wdata[47:0];
            mvpd_pkg::CSR_INTEGRAL_LIMITS: integral_limits_in = csr_wdata;
            mvpd_pkg::CSR_PERIOD_SCALE:    period_scale_in    = csr_wdata[15:0];
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         running_in = req_running;
         sp_pos_in  = req_setpoint_position;
         sp_vel_in  = req_setpoint_velocity;
         own_pos_in = req_own_position;
         vi_in      = req_vehicle_index;
         veh_pos_in = req_vehicle_position;
         veh_vel_in = req_vehicle_velocity;
         last_in    = req_last_vehicle;
         busy_in    = 1'b1;
         step_in    = mvpd_pkg::STEP_START;
      end

      if (busy_ff) begin
         if (jump_take) begin
            step_in = cw.jmp_target;
         end else begin
            if (cw.mul_op != mvpd_pkg::MUL_NONE) begin
               prod_in = mul_p;
            end

            case (cw.acc_op)
               mvpd_pkg::ACC_INTEG: begin
                  integ_in[vi_ff[IDX_W-1:0]] = acc_clamp[39:0];
                  acc_in                     = acc_clamp[39:0];
               end
               mvpd_pkg::ACC_TINT,
               mvpd_pkg::ACC_TPOS,
               mvpd_pkg::ACC_TVEL: begin
                  sum_in = sum_sat;
               end
               default: ;
            endcase

            case (cw.fin_op)
               mvpd_pkg::FIN_RUN: begin
                  was_running_in = 1'b1;
                  stored_sp_in   = sp_pos_ff;
                  if (!last_ff) begin
                     busy_in = 1'b0;
                  end else if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_drive_in  = drive_clamp;
                     rsp_recal_in  = 1'b0;
                     rsp_offset_in = '0;
                     sum_in        = '0;
                     busy_in       = 1'b0;
                  end
               end
               mvpd_pkg::FIN_STOP: begin
                  if (out_free) begin
                     rsp_valid_in  = 1'b1;
                     rsp_drive_in  = '0;
                     rsp_recal_in  = was_running_ff;
                     rsp_offset_in = was_running_ff ? offset_diff : 17'sd0;
                     for (int i = 0; i < VEHICLES; i++) begin
                        integ_in[i] = '0;
                     end
                     sum_in         = '0;
                     was_running_in = 1'b0;
                     busy_in        = 1'b0;
                  end
               end
               default: begin
                  step_in = step_ff + 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_index_ff       <= '0;
         integral_gains_ff  <= '0;
         position_gains_ff  <= '0;
         velocity_gains_ff  <= '0;
         integral_limits_ff <= {60{1'b1}};
         period_scale_ff    <= 16'd131;
         busy_ff            <= 1'b0;
         step_ff            <= mvpd_pkg::STEP_START;
         integ_ff           <= '{default: '0};
         sum_ff             <= '0;
         stored_sp_ff       <= '0;
         was_running_ff     <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         own_index_ff       <= own_index_in;
         integral_gains_ff  <= integral_gains_in;
         position_gains_ff  <= position_gains_in;
         velocity_gains_ff  <= velocity_gains_in;
         integral_limits_ff <= integral_limits_in;
         period_scale_ff    <= period_scale_in;
         busy_ff            <= busy_in;
         step_ff            <= step_in;
         integ_ff           <= integ_in;
         sum_ff             <= sum_in;
         stored_sp_ff       <= stored_sp_in;
         was_running_ff     <= was_running_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      running_ff    <= running_in;
      sp_pos_ff     <= sp_pos_in;
      sp_vel_ff     <= sp_vel_in;
      own_pos_ff    <= own_pos_in;
      vi_ff         <= vi_in;
      veh_pos_ff    <= veh_pos_in;
      veh_vel_ff    <= veh_vel_in;
      last_ff       <= last_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_drive_ff  <= rsp_drive_in;
      rsp_recal_ff  <= rsp_recal_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive           = rsp_drive_ff;
   assign rsp_recalibrate     = rsp_recal_ff;
   assign rsp_position_offset = rsp_offset_ff;

endmodule

`default_nettype wire

// File: rtl/mvpd_checker.sv
// Port-level checker for the drive unit, bound to the top level.
`default_nettype none

`include "multi_vehicle_pi_drive_unit_macros.svh"

module mvpd_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_drive,
   input logic               rsp_recalibrate,
   input logic signed [16:0] rsp_position_offset
);

   // The drive never leaves plus or minus 1.0.
   `MVPD_ASSERT_SAME(a_drive_range, rsp_valid, (rsp_drive <= mvpd_pkg::DRIVE_MAX) && (rsp_drive >= mvpd_pkg::DRIVE_MIN), "drive beyond plus or minus one")

   // A recalibration only comes from a stopped beat, which drives zero.
   `MVPD_ASSERT_SAME(a_recal_drive_zero, rsp_valid && rsp_recalibrate, rsp_drive == 16'sd0, "recalibrate with nonzero drive")

   `MVPD_ASSERT_SAME(a_offset_needs_recal, rsp_valid && !rsp_recalibrate, rsp_position_offset == 17'sd0, "position offset without recalibrate")

   // Accepting a beat sets the busy flag, so the block is not ready right after it.
   `MVPD_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready right after an accepted beat")

   `MVPD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_drive) && $stable(rsp_recalibrate) && $stable(rsp_position_offset), "stalled response changed")

endmodule

bind multi_vehicle_pi_drive_unit mvpd_checker u_mvpd_checker (.*);

`default_nettype wire

// File: dv/tb_multi_vehicle_pi_drive_unit.sv
// Self-checking testbench for the multi-vehicle PI drive unit, with its scoreboard.
`default_nettype none

typedef struct {
   logic               running;
   logic signed [15:0] setpoint_position;
   logic signed [15:0] setpoint_velocity;
   logic signed [15:0] own_position;
   logic [1:0]         vehicle_index;
   logic signed [15:0] vehicle_position;
   logic signed [15:0] vehicle_velocity;
   logic               last_vehicle;
} vehicle_beat_type;

typedef struct {
   logic signed [15:0] drive;
   logic               recalibrate;
   logic signed [16:0] position_offset;
} drive_result_type;

class drive_scoreboard;
   logic [1:0]       own_index;
   logic [47:0]      int_gains;
   logic [47:0]      pos_gains;
   logic [47:0]      vel_gains;
   logic [59:0]      int_limits;
   logic [15:0]      period;
   longint           integral [mvpd_pkg::VEHICLES_DEF];
   longint           drive_sum;
   longint           stored_setpoint;
   bit               was_running;
   drive_result_type expected_drives [$];
   int               failures;

   function new();
      own_index       = '0;
      int_gains       = '0;
      pos_gains       = '0;
      vel_gains       = '0;
      int_limits      = '1;
      period          = 16'd131;
      foreach (integral[i]) integral[i] = 0;
      drive_sum       = 0;
      stored_setpoint = 0;
      was_running     = 1'b0;
      failures        = 0;
   endfunction

   function void set_register(logic [2:0] idx, logic [59:0] value);
      case (idx)
         mvpd_pkg::CSR_OWN_INDEX:       own_index  = value[1:0];
         mvpd_pkg::CSR_INTEGRAL_GAINS:  int_gains  = value[47:0];
         mvpd_pkg::CSR_POSITION_GAINS:  pos_gains  = value[47:0];
         mvpd_pkg::CSR_VELOCITY_GAINS:  vel_gains  = value[47:0];
         mvpd_pkg::CSR_INTEGRAL_LIMITS: int_limits = value;
         mvpd_pkg::CSR_PERIOD_SCALE:    period     = value[15:0];
         default: ;
      endcase
   endfunction

   function longint rounded_shift(longint x, int k);
      longint half;
      half = longint'(1) << (k - 1);
      return (x + half) >>> k;
   endfunction

   function longint clamp48(longint x);
      longint hi;
      hi = (longint'(1) << 47) - 1;
      if (x > hi) return hi;
      if (x < -hi - 1) return -hi - 1;
      return x;
   endfunction

   function int pending();
      return expected_drives.size();
   endfunction

   function void take_vehicle_beat(vehicle_beat_type b);
      drive_result_type r;
      longint           sp, spv, own, vp, vv, pos, lim, acc, per;
      longint           g_int, g_pos, g_vel, d, diff;
      int               vi;
      sp  = b.setpoint_position;
      spv = b.setpoint_velocity;
      own = b.own_position;
      vp  = b.vehicle_position;
      vv  = b.vehicle_velocity;
      vi  = b.vehicle_index;
      if (!b.running) begin
         diff              = own - stored_setpoint;
         r.drive           = '0;
         r.recalibrate     = was_running;
         r.position_offset = was_running ? diff[16:0] : '0;
         foreach (integral[i]) integral[i] = 0;
         drive_sum   = 0;
         was_running = 1'b0;
         expected_drives.push_back(r);
         return;
      end
      was_running     = 1'b1;
      stored_setpoint = sp;
      if (vi < mvpd_pkg::VEHICLES_DEF) begin
         lim   = int_limits[20*vi +: 20];
         lim   = lim << 16;
         per   = period;
         acc   = integral[vi] + per * (sp - own);
         if (acc > lim) acc = lim;
         if (acc < -lim) acc = -lim;
         integral[vi] = acc;
         g_int = $signed(int_gains[16*vi +: 16]);
         g_pos = $signed(pos_gains[16*vi +: 16]);
         g_vel = $signed(vel_gains[16*vi +: 16]);
         // The local vehicle uses the beat's own position, not its vehicle position.
         pos   = (vi == own_index) ? own : vp;
         drive_sum = clamp48(drive_sum + rounded_shift(g_int * acc, 14));
         drive_sum = clamp48(drive_sum + g_pos * (sp - pos) * 4);
         drive_sum = clamp48(drive_sum + rounded_shift(g_vel * (spv - vv), 6));
      end
      if (b.last_vehicle) begin
         d = drive_sum;
         if (d > 16384) d = 16384;
         if (d < -16384) d = -16384;
         drive_sum         = 0;
         r.drive           = d[15:0];
         r.recalibrate     = 1'b0;
         r.position_offset = '0;
         expected_drives.push_back(r);
      end
   endfunction

   function void check_drive_beat(logic signed [15:0] drive, logic recalibrate,
                                  logic signed [16:0] position_offset);
      drive_result_type e;
      if (expected_drives.size() == 0) begin
         $error("unexpected result beat: drive %0d recalibrate %0d position_offset %0d",
                drive, recalibrate, position_offset);
         failures++;
         return;
      end
      e = expected_drives.pop_front();
      if (drive !== e.drive) begin
         $error("drive: expected %0d, got %0d", e.drive, drive);
         failures++;
      end
      if (recalibrate !== e.recalibrate) begin
         $error("recalibrate: expected %0d, got %0d", e.recalibrate, recalibrate);
         failures++;
      end
      if (position_offset !== e.position_offset) begin
         $error("position_offset: expected %0d, got %0d", e.position_offset,
                position_offset);
         failures++;
      end
   endfunction

   function int close_out();
      if (expected_drives.size() != 0) begin
         $error("%0d expected result beats never arrived", expected_drives.size());
         failures++;
      end
      return failures;
   endfunction
endclass

module tb_multi_vehicle_pi_drive_unit;

   localparam int N_VEHICLES   = mvpd_pkg::VEHICLES_DEF;
   localparam int N_PHASES     = 8;
   localparam int PHASE_BEATS  = 100;
   localparam int HOLD_CYCLES  = 400;
   localparam int IDLE_CYCLES  = 16;
   localparam int DRAIN_LIMIT  = 20000;

   // Indexes past the register list; writes there must change nothing.
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_wen = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [59:0]        csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_running = 1'b0;
   logic signed [15:0] req_setpoint_position = '0;
   logic signed [15:0] req_setpoint_velocity = '0;
   logic signed [15:0] req_own_position = '0;
   logic [1:0]         req_vehicle_index = '0;
   logic signed [15:0] req_vehicle_position = '0;
   logic signed [15:0] req_vehicle_velocity = '0;
   logic               req_last_vehicle = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_drive;
   logic               rsp_recalibrate;
   logic signed [16:0] rsp_position_offset;

   bit                 steady = 1'b0;
   bit                 hold_rsp = 1'b0;
   int                 beats_sent = 0;
   drive_scoreboard    sb;

   multi_vehicle_pi_drive_unit #(
      .VEHICLES(N_VEHICLES)
   ) uut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wen               (csr_wen),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_running           (req_running),
      .req_setpoint_position (req_setpoint_position),
      .req_setpoint_velocity (req_setpoint_velocity),
      .req_own_position      (req_own_position),
      .req_vehicle_index     (req_vehicle_index),
      .req_vehicle_position  (req_vehicle_position),
      .req_vehicle_velocity  (req_vehicle_velocity),
      .req_last_vehicle      (req_last_vehicle),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_drive             (rsp_drive),
      .rsp_recalibrate       (rsp_recalibrate),
      .rsp_position_offset   (rsp_position_offset)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("Some tests failed");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_word();
      int r;
      int s;
      r = $urandom_range(0, 9);
      case (r)
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         4, 5, 6: begin
            s = $urandom_range(0, 400);
            s -= 200;
            return s[15:0];
         end
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_gain(input int ph);
      int r;
      int s;
      r = $urandom_range(0, 99);
      if (ph == 1) return r[0] ? 16'h7FFF : 16'h8000;
      if (ph == 7 || r >= 85) return 16'($urandom);
      s = (r < 70) ? $urandom_range(0, 512) : $urandom_range(0, 8192);
      s -= (r < 70) ? 256 : 4096;
      return s[15:0];
   endfunction

   function automatic vehicle_beat_type make_beat(
      input logic running, input logic [15:0] sp, input logic [15:0] spv,
      input logic [15:0] own, input logic [1:0] vi, input logic [15:0] vp,
      input logic [15:0] vv, input logic last);
      vehicle_beat_type b;
      b.running           = running;
      b.setpoint_position = sp;
      b.setpoint_velocity = spv;
      b.own_position      = own;
      b.vehicle_index     = vi;
      b.vehicle_position  = vp;
      b.vehicle_velocity  = vv;
      b.last_vehicle      = last;
      return b;
   endfunction

   // Valid stays up across back-to-back beats; it only drops for a gap or when settling.
   task automatic send_beat(input vehicle_beat_type b);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_running           <= b.running;
      req_setpoint_position <= b.setpoint_position;
      req_setpoint_velocity <= b.setpoint_velocity;
      req_own_position      <= b.own_position;
      req_vehicle_index     <= b.vehicle_index;
      req_vehicle_position  <= b.vehicle_position;
      req_vehicle_velocity  <= b.vehicle_velocity;
      req_last_vehicle      <= b.last_vehicle;
      req_valid             <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.take_vehicle_beat(b);
      beats_sent++;
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [59:0] value);
      @(posedge clock);
      csr_index <= idx;
      csr_wdata <= value;
      csr_wen   <= 1'b1;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.set_register(idx, value);
   endtask

   // A running beat that yields no result may still be in flight when the
   // queue drains, so give the block its full latency before touching registers.
   task automatic settle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic configure_phase(input int ph);
      logic [47:0] ig, pg, vg;
      logic [59:0] lims;
      logic [15:0] per;
      int          r;
      for (int i = 0; i < N_VEHICLES; i++) begin
         ig[16*i +: 16] = pick_gain(ph);
         pg[16*i +: 16] = pick_gain(ph);
         vg[16*i +: 16] = pick_gain(ph);
         r = $urandom_range(0, 9);
         if (r == 0) lims[20*i +: 20] = '0;
         else if (r == 1) lims[20*i +: 20] = '1;
         else if (r < 4) lims[20*i +: 20] = 20'($urandom);
         else lims[20*i +: 20] = 20'($urandom_range(0, 2000));
      end
      if (ph == 0) lims = '1;
      if (ph == 3) lims = '0;
      case (ph)
         1:       per = 16'hFFFF;
         2:       per = 16'd131;
         4:       per = 16'h0000;
         default: per = 16'($urandom);
      endcase
      write_csr(mvpd_pkg::CSR_OWN_INDEX, 60'(ph % N_VEHICLES));
      write_csr(mvpd_pkg::CSR_INTEGRAL_GAINS, {12'd0, ig});
      write_csr(mvpd_pkg::CSR_POSITION_GAINS, {12'd0, pg});
      write_csr(mvpd_pkg::CSR_VELOCITY_GAINS, {12'd0, vg});
      write_csr(mvpd_pkg::CSR_INTEGRAL_LIMITS, lims);
      write_csr(mvpd_pkg::CSR_PERIOD_SCALE, {44'd0, per});
      if (ph == 2) begin
         write_csr(CSR_SPARE_LO, 60'({$urandom, $urandom}));
         write_csr(CSR_SPARE_HI, 60'({$urandom, $urandom}));
      end
   endtask

   // One well-formed control period: every vehicle once, the final beat marked last.
   task automatic send_period();
      logic [15:0] sp, spv, own, vp, vv;
      int          order [N_VEHICLES];
      int          delta, a, b, t;
      sp    = pick_word();
      spv   = pick_word();
      delta = $urandom_range(0, 200);
      delta -= 100;
      own   = ($urandom_range(0, 3) == 0) ? pick_word() : sp + delta[15:0];
      for (int k = 0; k < N_VEHICLES; k++) order[k] = k;
      if ($urandom_range(0, 3) == 0) begin
         a = $urandom_range(0, N_VEHICLES - 1);
         b = $urandom_range(0, N_VEHICLES - 1);
         t = order[a];
         order[a] = order[b];
         order[b] = t;
      end
      for (int k = 0; k < N_VEHICLES; k++) begin
         delta = $urandom_range(0, 300);
         delta -= 150;
         vp = ($urandom_range(0, 4) == 0) ? pick_word() : sp + delta[15:0];
         vv = ($urandom_range(0, 4) == 0) ? pick_word() : spv + delta[15:0];
         send_beat(make_beat(1'b1, sp, spv, own, order[k][1:0], vp, vv,
                             k == N_VEHICLES - 1));
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_drive_beat(rsp_drive, rsp_recalibrate, rsp_position_offset);
   end

   initial begin : rsp_side
      int n;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            for (n = 0; n < HOLD_CYCLES; n++) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            n = pick_gap();
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   initial begin
      int r;
      int target;
      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: all gains are zero, so only the stop handling shows.
      send_beat(make_beat(1'b0, 16'h0000, 16'h0000, 16'h0005, 2'd0, 16'h0000, 16'h0000,
                          1'b1));
      send_beat(make_beat(1'b1, 16'h8000, 16'h0100, 16'h0000, 2'd0, 16'h0010, 16'h0000,
                          1'b1));
      // Offset reaches its top: own at the maximum, stored setpoint at the minimum.
      send_beat(make_beat(1'b0, 16'h0000, 16'h0000, 16'h7FFF, 2'd1, 16'h0000, 16'h0000,
                          1'b0));
      settle();

      write_csr(mvpd_pkg::CSR_OWN_INDEX, 60'd1);
      write_csr(mvpd_pkg::CSR_INTEGRAL_GAINS, {12'd0, 16'h7FFF, 16'hF000, 16'h1000});
      write_csr(mvpd_pkg::CSR_POSITION_GAINS, {12'd0, 16'h8000, 16'hFFF0, 16'h0010});
      write_csr(mvpd_pkg::CSR_VELOCITY_GAINS, {12'd0, 16'h0001, 16'hFF00, 16'h0100});
      write_csr(mvpd_pkg::CSR_INTEGRAL_LIMITS, {20'd100, 20'hFFFFF, 20'd0});
      write_csr(mvpd_pkg::CSR_PERIOD_SCALE, 60'hFFFF);

      send_beat(make_beat(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000, 2'd0, 16'h8000, 16'h8000,
                          1'b0));
      send_beat(make_beat(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000, 2'd1, 16'h8000, 16'h8000,
                          1'b0));
      send_beat(make_beat(1'b1, 16'h7FFF, 16'h7FFF, 16'h8000, 2'd2, 16'h8000, 16'h8000,
                          1'b1));
      send_beat(make_beat(1'b1, 16'h8000, 16'h8000, 16'h7FFF, 2'd2, 16'h7FFF, 16'h7FFF,
                          1'b0));
      send_beat(make_beat(1'b1, 16'h8000, 16'h8000, 16'h7FFF, 2'd0, 16'h7FFF, 16'h7FFF,
                          1'b0));
      send_beat(make_beat(1'b1, 16'h8000, 16'h8000, 16'h7FFF, 2'd1, 16'h7FFF, 16'h7FFF,
                          1'b1));
      // An unknown vehicle index touches no integral and adds no drive term but still closes the period.
      send_beat(make_beat(1'b1, 16'h1234, 16'hFFFF, 16'hFFFF, 2'd3, 16'h7FFF, 16'h7FFF,
                          1'b0));
      send_beat(make_beat(1'b1, 16'h1234, 16'hFFFF, 16'hFFFF, 2'd3, 16'h8000, 16'h8000,
                          1'b1));
      send_beat(make_beat(1'b1, 16'h7FFF, 16'h0000, 16'h0000, 2'd1, 16'h0000, 16'h0000,
                          1'b0));
      // Stop in mid-period; the offset reaches its bottom.
      send_beat(make_beat(1'b0, 16'h0000, 16'h0000, 16'h8000, 2'd2, 16'h0000, 16'h0000,
                          1'b0));
      send_beat(make_beat(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF, 16'hFFFF,
                          1'b1));
      send_beat(make_beat(1'b1, 16'h0040, 16'h0080, 16'h0030, 2'd0, 16'h0020, 16'h0070,
                          1'b1));

      for (int ph = 0; ph < N_PHASES; ph++) begin
         settle();
         configure_phase(ph);
         steady = (ph == 5);
         if (ph == 6) hold_rsp = 1'b1;
         target = beats_sent + PHASE_BEATS;
         while (beats_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 78) begin
               send_period();
            end else if (r < 88) begin
               send_beat(make_beat(1'b0, pick_word(), pick_word(), pick_word(),
                                   2'($urandom_range(0, 3)), pick_word(), pick_word(),
                                   1'($urandom_range(0, 1))));
            end else begin
               send_beat(make_beat(1'($urandom_range(0, 1)), pick_word(), pick_word(),
                                   pick_word(), 2'($urandom_range(0, 3)), pick_word(),
                                   pick_word(), 1'($urandom_range(0, 1))));
            end
         end
      end
      steady = 1'b0;
      settle();

      if (sb.close_out() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/mvpd_pkg.sv
rtl/multi_vehicle_pi_drive_unit.sv
rtl/mvpd_checker.sv
dv/tb_multi_vehicle_pi_drive_unit.sv
